[rtl/pctb_pkg.sv]
// Package for the per-client token bucket table.
// Holds the shared types, register indexes, verdict codes and fixed constants.
// No dependencies.
package pctb_pkg;

    localparam int KEY_W   = 32;
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 24;
    localparam int CNT32_W = 32;
    localparam int PROD_W  = TIME_W + LEVEL_W;

    // One whole token in Q8 fixed point.
    localparam logic [LEVEL_W-1:0] ONE_TOKEN_Q8 = 24'd256;

    localparam logic [LEVEL_W-1:0] CAPACITY_RESET = 24'd2560;
    localparam logic [LEVEL_W-1:0] RATE_RESET     = 24'd256;

    typedef enum logic [0:0] {
        CFG_CAPACITY = 1'b0,
        CFG_RATE     = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_ALLOW      = 2'd0,
        VERDICT_NO_TOKENS  = 2'd1,
        VERDICT_TABLE_FULL = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_ADD,
        ST_FIN
    } state_t;

    // Search record handed from cell to cell.
    typedef struct packed {
        logic               active;
        logic               hit;
        logic [KEY_W-1:0]   key;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  last_time;
    } rec_t;

    // Entry write broadcast to every cell.
    typedef struct packed {
        logic               we;
        logic [KEY_W-1:0]   key;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  last_time;
    } wr_t;

endpackage

[rtl/pctb_if.sv]
// Handshake interfaces for the request and result channels.
// Each carries valid, ready and the payload; no package dependency.
interface pctb_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] client_key;
    logic [31:0] now_sec;

    modport source (output valid, output client_key, output now_sec, input ready);
    modport sink (input valid, input client_key, input now_sec, output ready);
endinterface

interface pctb_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [5:0]  client_slot;
    logic [23:0] tokens_left;
    logic [31:0] blocked_total;

    modport source (output valid, output verdict, output client_slot, output tokens_left,
                    output blocked_total, input ready);
    modport sink (input valid, input verdict, input client_slot, input tokens_left,
                  input blocked_total, output ready);
endinterface

[rtl/pctb_cell.sv]
// One table cell: holds one client entry and compares it against the passing search record.
// Depends on pctb_pkg.
module pctb_cell
    import pctb_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int SLOT_W = 6,
    parameter int CNT_W  = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  count,
    input  rec_t              rec_in,
    input  logic [SLOT_W-1:0] slot_in,
    output rec_t              rec_out,
    output logic [SLOT_W-1:0] slot_out,
    input  wr_t               wr,
    input  logic [SLOT_W-1:0] wr_slot
);

    logic [KEY_W-1:0]   key_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]  time_reg;
    rec_t               rec_reg;
    rec_t               rec_next;
    logic               active_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic               match;

    // Only the first matching entry in use claims the record.
    assign match = rec_in.active && !rec_in.hit && (CNT_W'(IDX) < count)
                   && (key_reg == rec_in.key);

    always_comb
    begin
        rec_next  = rec_in;
        slot_next = slot_in;
        if (match)
        begin
            rec_next.hit       = 1'b1;
            rec_next.level     = level_reg;
            rec_next.last_time = time_reg;
            slot_next          = SLOT_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= rec_next.active;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        slot_reg <= slot_next;
        if (wr.we && (wr_slot == SLOT_W'(IDX)))
        begin
            key_reg   <= wr.key;
            level_reg <= wr.level;
            time_reg  <= wr.last_time;
        end
    end

    // The valid flag comes from the reset register; the rest of the record needs no reset.
    always_comb
    begin
        rec_out        = rec_reg;
        rec_out.active = active_reg;
    end

    assign slot_out = slot_reg;

endmodule

[rtl/per_client_token_bucket_table.sv]
// Per-client token bucket table: a result is valid once the request has passed the cell row and the refill steps.
// The key walks the row of cells one cell per clock, then the multiply, add and update
// states follow; the update waits while the output register is full, and the next request
// can be taken in the cycle the result appears.
// One request is in flight at a time; a finished result waits in the output register.
// Reset clears control state, entry count and blocked counter and loads register defaults.
module per_client_token_bucket_table
    import pctb_pkg::*;
#(
    parameter int MAX_CLIENTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    pctb_req_if.sink            req,
    pctb_res_if.source          res,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [LEVEL_W-1:0]  cfg_data
);

    localparam int SLOT_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);

    // Control state.
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [31:0]        denied_reg;
    logic [31:0]        denied_next;
    logic [LEVEL_W-1:0] cap_reg;
    logic [LEVEL_W-1:0] rate_reg;

    // Per-request working registers.
    logic [KEY_W-1:0]   key_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               miss_reg;
    logic               full_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]  last_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               adv_reg;
    logic [LEVEL_W-1:0] lvl_reg;

    // Output register.
    logic               res_valid_reg;
    logic               res_valid_next;
    verdict_t           verdict_reg;
    logic [5:0]         slot_out_reg;
    logic [LEVEL_W-1:0] tokens_reg;
    logic [31:0]        blocked_reg;

    logic               accept;
    logic               out_free;
    logic               load_out;
    logic               allow;
    logic [LEVEL_W-1:0] new_level;
    logic [PROD_W:0]    sum;
    logic [LEVEL_W-1:0] lvl_clamp;
    logic [TIME_W-1:0]  elapsed;
    wr_t                wr;

    rec_t               chain [MAX_CLIENTS+1];
    logic [SLOT_W-1:0]  chain_slot [MAX_CLIENTS+1];

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !res_valid_reg || res.ready;

    // The search record enters the first cell in the cycle the request is taken.
    always_comb
    begin
        chain[0].active    = accept;
        chain[0].hit       = 1'b0;
        chain[0].key       = req.client_key;
        chain[0].level     = '0;
        chain[0].last_time = '0;
        chain_slot[0]      = '0;
    end

    for (genvar i = 0; i < MAX_CLIENTS; i++)
    begin : g_cell
        pctb_cell #(
            .IDX    (i),
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (count_reg),
            .rec_in   (chain[i]),
            .slot_in  (chain_slot[i]),
            .rec_out  (chain[i+1]),
            .slot_out (chain_slot[i+1]),
            .wr       (wr),
            .wr_slot  (slot_reg)
        );
    end

    // Refill arithmetic: the product is registered before the saturating add.
    assign elapsed   = now_reg - last_reg;
    assign sum       = {{(PROD_W + 1 - LEVEL_W){1'b0}}, level_reg} + {1'b0, prod_reg};
    assign lvl_clamp = (sum > {{(PROD_W + 1 - LEVEL_W){1'b0}}, cap_reg}) ? cap_reg
                                                                          : sum[LEVEL_W-1:0];

    assign allow     = (lvl_reg >= ONE_TOKEN_Q8);
    assign new_level = allow ? (lvl_reg - ONE_TOKEN_Q8) : lvl_reg;
    assign load_out  = (state_reg == ST_FIN) && out_free;

    // Entry write-back; the refill time moves only when time advanced.
    always_comb
    begin
        wr.we        = load_out && !full_reg;
        wr.key       = key_reg;
        wr.level     = new_level;
        wr.last_time = adv_reg ? now_reg : last_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        denied_next    = denied_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (chain[MAX_CLIENTS].active)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    if (!full_reg)
                    begin
                        if (miss_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        if (!allow && (denied_reg != 32'hFFFF_FFFF))
                        begin
                            denied_next = denied_reg + 32'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            denied_reg    <= '0;
            res_valid_reg <= 1'b0;
            cap_reg       <= CAPACITY_RESET;
            rate_reg      <= RATE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            denied_reg    <= denied_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_CAPACITY: cap_reg  <= cfg_data;
                    CFG_RATE:     rate_reg <= cfg_data;
                endcase
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= req.client_key;
            now_reg <= req.now_sec;
        end
        if ((state_reg == ST_SEARCH) && chain[MAX_CLIENTS].active)
        begin
            miss_reg <= !chain[MAX_CLIENTS].hit;
            full_reg <= !chain[MAX_CLIENTS].hit && (count_reg >= CNT_W'(MAX_CLIENTS));
            if (chain[MAX_CLIENTS].hit)
            begin
                slot_reg  <= chain_slot[MAX_CLIENTS];
                level_reg <= chain[MAX_CLIENTS].level;
                last_reg  <= chain[MAX_CLIENTS].last_time;
            end
            else
            begin
                // A new entry starts full with the request time as its refill time.
                slot_reg  <= count_reg[SLOT_W-1:0];
                level_reg <= cap_reg;
                last_reg  <= now_reg;
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= {{(PROD_W - TIME_W){1'b0}}, elapsed}
                        * {{(PROD_W - LEVEL_W){1'b0}}, rate_reg};
            adv_reg  <= (now_reg > last_reg);
        end
        if (state_reg == ST_ADD)
        begin
            lvl_reg <= adv_reg ? lvl_clamp : level_reg;
        end
        if (load_out)
        begin
            if (full_reg)
            begin
                verdict_reg  <= VERDICT_TABLE_FULL;
                slot_out_reg <= '0;
                tokens_reg   <= '0;
            end
            else
            begin
                verdict_reg  <= allow ? VERDICT_ALLOW : VERDICT_NO_TOKENS;
                slot_out_reg <= 6'(slot_reg);
                tokens_reg   <= new_level;
            end
            blocked_reg <= denied_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.verdict       = verdict_reg;
    assign res.client_slot   = slot_out_reg;
    assign res.tokens_left   = tokens_reg;
    assign res.blocked_total = blocked_reg;

endmodule

[rtl/pctb_checker.sv]
// Port-level checks for the per-client token bucket table, bound to the top level.
// Depends on pctb_pkg.
module pctb_checker
    import pctb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  verdict,
    input logic [5:0]  client_slot,
    input logic [23:0] tokens_left
);

    // Only one request is in flight, so the request side closes after a transaction.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in flight");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(verdict)))
        else $error("stalled result changed");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (verdict == VERDICT_TABLE_FULL)) |-> (client_slot == 6'd0
            && tokens_left == 24'd0))
        else $error("table-full result carries slot or tokens");

    a_denied_level: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (verdict == VERDICT_NO_TOKENS)) |-> (tokens_left < ONE_TOKEN_Q8))
        else $error("denied with a whole token left");

endmodule

bind per_client_token_bucket_table pctb_checker u_pctb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .verdict     (res.verdict),
    .client_slot (res.client_slot),
    .tokens_left (res.tokens_left)
);
